FILE: src/cb1a_pkg.sv
// cb1a_pkg: shared types, constants, microcode table and saturation helpers
// for the presynaptic release / CB1 adaptation block. No dependencies.
`default_nettype none

package cb1a_pkg;

	localparam int NUM_STEPS = 11;
	localparam int PC_W      = $clog2(NUM_STEPS);

	localparam logic [2:0] CFG_RISE_STEP    = 3'd0;
	localparam logic [2:0] CFG_FALL_STEP    = 3'd1;
	localparam logic [2:0] CFG_RECOVER_STEP = 3'd2;
	localparam logic [2:0] CFG_ADAPT_RATE   = 3'd3;
	localparam logic [2:0] CFG_MAX_TRANS    = 3'd4;
	localparam logic [2:0] CFG_GOODWIN_CONN = 3'd5;
	localparam logic [2:0] CFG_ECB_CONN     = 3'd6;

	localparam logic [PC_W-1:0] STEP_NOECB = PC_W'(6);
	localparam logic [PC_W-1:0] STEP_CUR   = PC_W'(7);

	typedef enum logic [2:0] {
		A_AVAIL,
		A_GY,
		A_EL,
		A_ECB_RISE,
		A_RISE_CUR,
		A_MAX_AVAIL,
		A_RATE
	} a_sel_t;

	typedef enum logic [2:0] {
		B_SW,
		B_GW,
		B_EW,
		B_RISE,
		B_FALL,
		B_RECOVER,
		B_MIN
	} b_sel_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_REL,
		WB_REC,
		WB_ECB,
		WB_UNB,
		WB_RISE,
		WB_NOECB,
		WB_CUR,
		WB_ACC,
		WB_AVAIL
	} wb_op_t;

	typedef enum logic [1:0] {
		J_NONE,
		J_NO_ECB,
		J_ALWAYS
	} jmp_t;

	typedef struct packed {
		logic            mul_en;
		a_sel_t          a_sel;
		b_sel_t          b_sel;
		wb_op_t          wb;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
		logic            last;
	} cw_t;

	typedef struct packed {
		cw_t  cw;
		logic exec;
		logic load_in;
	} ctrl_t;

	// microprogram: a step multiplies into the product register and/or writes
	// back the product formed by the step before
	function automatic cw_t ucode(logic [PC_W-1:0] pc);
		cw_t w;
		w = '{mul_en: 1'b0, a_sel: A_AVAIL, b_sel: B_SW, wb: WB_NONE,
			jmp: J_NONE, target: '0, last: 1'b0};
		unique case (pc)
			PC_W'(0): begin
				w.mul_en = 1'b1; w.a_sel = A_AVAIL; w.b_sel = B_SW;
			end
			PC_W'(1): begin
				w.mul_en = 1'b1; w.a_sel = A_GY; w.b_sel = B_GW; w.wb = WB_REL;
			end
			PC_W'(2): begin
				w.mul_en = 1'b1; w.a_sel = A_EL; w.b_sel = B_EW; w.wb = WB_REC;
				w.jmp = J_NO_ECB; w.target = STEP_NOECB;
			end
			PC_W'(3): begin
				w.wb = WB_ECB;
			end
			PC_W'(4): begin
				w.mul_en = 1'b1; w.a_sel = A_ECB_RISE; w.b_sel = B_RISE; w.wb = WB_UNB;
			end
			PC_W'(5): begin
				w.wb = WB_RISE; w.jmp = J_ALWAYS; w.target = STEP_CUR;
			end
			PC_W'(6): begin
				w.wb = WB_NOECB;
			end
			PC_W'(7): begin
				w.mul_en = 1'b1; w.a_sel = A_RISE_CUR; w.b_sel = B_FALL;
			end
			PC_W'(8): begin
				w.mul_en = 1'b1; w.a_sel = A_MAX_AVAIL; w.b_sel = B_RECOVER; w.wb = WB_CUR;
			end
			PC_W'(9): begin
				w.mul_en = 1'b1; w.a_sel = A_RATE; w.b_sel = B_MIN; w.wb = WB_ACC;
			end
			PC_W'(10): begin
				w.wb = WB_AVAIL; w.last = 1'b1;
			end
			default: begin
				w.last = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic logic signed [15:0] sat_s16(logic signed [21:0] x);
		logic signed [15:0] r;
		if (x > 22'sd32767)
			r = 16'sh7fff;
		else if (x < -22'sd32768)
			r = 16'sh8000;
		else
			r = x[15:0];
		return r;
	endfunction

	function automatic logic [14:0] sat_u15(logic signed [21:0] x);
		logic [14:0] r;
		if (x < 22'sd0)
			r = '0;
		else if (x > 22'sd32767)
			r = 15'h7fff;
		else
			r = x[14:0];
		return r;
	endfunction

	function automatic logic [12:0] sat_one(logic signed [21:0] x);
		logic [12:0] r;
		if (x < 22'sd0)
			r = '0;
		else if (x > 22'sd4096)
			r = 13'd4096;
		else
			r = x[12:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/cb1a_ctrl.sv
// cb1a_ctrl: microcode sequencer - step counter, control table lookup,
// conditional jumps, input/output transfer control. Uses cb1a_pkg.
`default_nettype none

module cb1a_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire logic           ecb_conn,
	output cb1a_pkg::ctrl_t     ctl
);

	logic                      busy_q;
	logic [cb1a_pkg::PC_W-1:0] pc_q;
	logic                      out_valid_q;
	cb1a_pkg::cw_t             cw;
	logic                      hold;
	logic                      exec;
	logic                      take;
	logic                      jump;

	assign cw   = cb1a_pkg::ucode(pc_q);
	assign hold = cw.last && out_valid_q && out_stall;
	assign exec = busy_q && !hold;
	assign take = in_valid && !busy_q;

	always_comb begin
		unique case (cw.jmp)
			cb1a_pkg::J_NO_ECB: jump = !ecb_conn;
			cb1a_pkg::J_ALWAYS: jump = 1'b1;
			default:            jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (exec) begin
				if (cw.last)
					busy_q <= 1'b0;
				pc_q <= jump ? cw.target : pc_q + 1'b1;
			end
			if (exec && cw.last)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall    = busy_q;
	assign out_valid   = out_valid_q;
	assign ctl.cw      = cw;
	assign ctl.exec    = exec;
	assign ctl.load_in = take;

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < cb1a_pkg::PC_W'(cb1a_pkg::NUM_STEPS)))
		else $error("step counter out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (busy_q && pc_q == '0))
		else $error("accepted transfer did not start program");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && cw.last) |=> (out_valid_q && !busy_q))
		else $error("last step did not post a result");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result posted without a program running");

endmodule

`default_nettype wire

FILE: src/cb1a_datapath.sv
// cb1a_datapath: config registers, input capture, shared multiplier,
// state registers, saturating writeback and output registers. Uses cb1a_pkg.
`default_nettype none

module cb1a_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cb1a_pkg::ctrl_t    ctl,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [14:0]        cfg_data,
	output logic                    ecb_conn,
	input  wire logic               spike,
	input  wire logic [14:0]        spike_weight,
	input  wire logic signed [15:0] goodwin_y,
	input  wire logic signed [15:0] goodwin_weight,
	input  wire logic signed [15:0] ecb_level,
	input  wire logic signed [15:0] ecb_weight,
	output logic [14:0]             released,
	output logic [12:0]             receptor_level,
	output logic [14:0]             unbound_level,
	output logic signed [15:0]      current_trace,
	output logic [14:0]             available_level
);

	logic [12:0] rise_step_q, fall_step_q, recover_step_q;
	logic [14:0] adapt_rate_q, max_trans_q;
	logic        gw_conn_q, ecb_conn_q;

	logic               spike_q;
	logic [14:0]        sw_q;
	logic signed [15:0] gy_q, gw_q, el_q, ew_q;

	logic [12:0]        rec_q;
	logic signed [15:0] rise_q, cur_q, ecb_q;
	logic [14:0]        avail_q, rel_q, unb_q;
	logic signed [21:0] acc_q;
	logic signed [20:0] prod_q;

	logic signed [16:0] a_mux;
	logic signed [15:0] b_mux;
	logic signed [32:0] product;
	logic signed [15:0] rec_s, min_v;
	logic signed [21:0] pq, rise_sum, cur_sum, unb_diff, acc_sum, avail_diff;
	logic [14:0]        avail_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_step_q    <= 13'd410;
			fall_step_q    <= 13'd410;
			recover_step_q <= 13'd410;
			adapt_rate_q   <= 15'd0;
			max_trans_q    <= 15'd4096;
			gw_conn_q      <= 1'b0;
			ecb_conn_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cb1a_pkg::CFG_RISE_STEP:    rise_step_q    <= cfg_data[12:0];
				cb1a_pkg::CFG_FALL_STEP:    fall_step_q    <= cfg_data[12:0];
				cb1a_pkg::CFG_RECOVER_STEP: recover_step_q <= cfg_data[12:0];
				cb1a_pkg::CFG_ADAPT_RATE:   adapt_rate_q   <= cfg_data;
				cb1a_pkg::CFG_MAX_TRANS:    max_trans_q    <= cfg_data;
				cb1a_pkg::CFG_GOODWIN_CONN: gw_conn_q      <= cfg_data[0];
				cb1a_pkg::CFG_ECB_CONN:     ecb_conn_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ecb_conn = ecb_conn_q;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			spike_q <= spike;
			sw_q    <= spike_weight;
			gy_q    <= goodwin_y;
			gw_q    <= goodwin_weight;
			el_q    <= ecb_level;
			ew_q    <= ecb_weight;
		end
	end

	assign rec_s = $signed({3'b000, rec_q});
	assign min_v = (ecb_q < rec_s) ? ecb_q : rec_s;

	always_comb begin
		case (ctl.cw.a_sel)
			cb1a_pkg::A_AVAIL:     a_mux = $signed({2'b00, avail_q});
			cb1a_pkg::A_GY:        a_mux = 17'(gy_q);
			cb1a_pkg::A_EL:        a_mux = 17'(el_q);
			cb1a_pkg::A_ECB_RISE:  a_mux = 17'(ecb_q) - 17'(rise_q);
			cb1a_pkg::A_RISE_CUR:  a_mux = 17'(rise_q) - 17'(cur_q);
			cb1a_pkg::A_MAX_AVAIL: a_mux = $signed({2'b00, max_trans_q})
				- $signed({2'b00, avail_q});
			cb1a_pkg::A_RATE:      a_mux = $signed({2'b00, adapt_rate_q});
			default:               a_mux = '0;
		endcase
		case (ctl.cw.b_sel)
			cb1a_pkg::B_SW:      b_mux = $signed({1'b0, sw_q});
			cb1a_pkg::B_GW:      b_mux = gw_q;
			cb1a_pkg::B_EW:      b_mux = ew_q;
			cb1a_pkg::B_RISE:    b_mux = $signed({3'b000, rise_step_q});
			cb1a_pkg::B_FALL:    b_mux = $signed({3'b000, fall_step_q});
			cb1a_pkg::B_RECOVER: b_mux = $signed({3'b000, recover_step_q});
			cb1a_pkg::B_MIN:     b_mux = min_v;
			default:             b_mux = '0;
		endcase
	end

	assign product = a_mux * b_mux;

	// floor(x / 4096) is the arithmetic shift of the two's complement product
	always_ff @(posedge clk) begin
		if (ctl.exec && ctl.cw.mul_en)
			prod_q <= product[32:12];
	end

	assign pq         = 22'(prod_q);
	assign rise_sum   = 22'(rise_q) + pq;
	assign cur_sum    = 22'(cur_q) + pq;
	assign unb_diff   = $signed({9'd0, rec_q}) - 22'(ecb_q);
	assign acc_sum    = $signed({7'd0, avail_q}) + pq;
	assign avail_diff = acc_q - pq;
	assign avail_new  = cb1a_pkg::sat_u15(avail_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q   <= '0;
			rise_q  <= '0;
			cur_q   <= '0;
			avail_q <= '0;
		end else if (ctl.exec) begin
			case (ctl.cw.wb)
				cb1a_pkg::WB_REC:
					if (gw_conn_q)
						rec_q <= cb1a_pkg::sat_one(pq);
				cb1a_pkg::WB_RISE:  rise_q  <= cb1a_pkg::sat_s16(rise_sum);
				cb1a_pkg::WB_NOECB: rise_q  <= '0;
				cb1a_pkg::WB_CUR:   cur_q   <= cb1a_pkg::sat_s16(cur_sum);
				cb1a_pkg::WB_AVAIL: avail_q <= avail_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			case (ctl.cw.wb)
				cb1a_pkg::WB_REL:   rel_q <= spike_q ? cb1a_pkg::sat_u15(pq) : '0;
				cb1a_pkg::WB_ECB:   ecb_q <= cb1a_pkg::sat_s16(pq);
				cb1a_pkg::WB_UNB:   unb_q <= cb1a_pkg::sat_u15(unb_diff);
				cb1a_pkg::WB_NOECB: begin
					ecb_q <= '0;
					unb_q <= {2'b00, rec_q};
				end
				cb1a_pkg::WB_ACC:   acc_q <= acc_sum;
				cb1a_pkg::WB_AVAIL: begin
					released        <= rel_q;
					receptor_level  <= rec_q;
					unbound_level   <= unb_q;
					current_trace   <= cur_q;
					available_level <= avail_new;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/presynaptic_release_cb1_adaptation.sv
// presynaptic_release_cb1_adaptation: top level, one bouton tick per transfer.
// Depends on cb1a_pkg, cb1a_ctrl, cb1a_datapath.
//
//   channel  handshake            payload
//   in       in_valid/in_stall    spike, spike_weight, goodwin_y, goodwin_weight,
//                                 ecb_level, ecb_weight
//   out      out_valid/out_stall  released, receptor_level, unbound_level,
//                                 current_trace, available_level
//   cfg      cfg_we               cfg_index, cfg_data
//
// A tick runs as a microprogram on one shared 17x16 multiplier: 10 steps with
// the eCB input connected, 8 without, after the input transfer.
// The single multiplier sets the count: seven products with eCB, six without,
// each written back by the step that follows it, but the eCB product without eCB.
// in_stall is high while a program runs; a finished result sits in the output
// registers, and the last step waits only if the previous result is still stalled.
// Reset clears the state and the config registers to their defaults; no sweep.
`default_nettype none

module presynaptic_release_cb1_adaptation (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               spike,
	input  wire logic [14:0]        spike_weight,
	input  wire logic signed [15:0] goodwin_y,
	input  wire logic signed [15:0] goodwin_weight,
	input  wire logic signed [15:0] ecb_level,
	input  wire logic signed [15:0] ecb_weight,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [14:0]             released,
	output logic [12:0]             receptor_level,
	output logic [14:0]             unbound_level,
	output logic signed [15:0]      current_trace,
	output logic [14:0]             available_level,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [14:0]        cfg_data
);

	cb1a_pkg::ctrl_t ctl;
	logic            ecb_conn;

	cb1a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ecb_conn  (ecb_conn),
		.ctl       (ctl)
	);

	cb1a_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.ecb_conn        (ecb_conn),
		.spike           (spike),
		.spike_weight    (spike_weight),
		.goodwin_y       (goodwin_y),
		.goodwin_weight  (goodwin_weight),
		.ecb_level       (ecb_level),
		.ecb_weight      (ecb_weight),
		.released        (released),
		.receptor_level  (receptor_level),
		.unbound_level   (unbound_level),
		.current_trace   (current_trace),
		.available_level (available_level)
	);

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// tb_top: self-checking testbench for presynaptic_release_cb1_adaptation.
// Directed rows, then random phases under several configs, checked per field
// against an in-bench tick model (the first rows against pinned values). Depends on cb1a_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int  Q_ONE       = 4096;
	localparam int  DIR_N       = 16;
	localparam int  DIR_SPLIT   = 5;
	localparam int  DIR_KNOWN   = 2;
	localparam int  N_PHASES    = 6;
	localparam int  PHASE_ITEMS = 290;
	localparam int  HOLD_CYCLES = 400;
	localparam int  DRAIN_PAUSE = 16;
	localparam int  WDOG_LIMIT  = 4000;

	localparam logic signed [15:0] S_MAX = 16'sh7fff;
	localparam logic signed [15:0] S_MIN = 16'sh8000;
	localparam logic signed [15:0] S_ONE = 16'sd4096;
	localparam logic signed [15:0] S_0   = 16'sd0;
	localparam logic [14:0]        U_MAX = 15'h7fff;

	typedef struct packed {
		logic               spike;
		logic [14:0]        sw;
		logic signed [15:0] gy;
		logic signed [15:0] gw;
		logic signed [15:0] el;
		logic signed [15:0] ew;
	} tick_in_t;

	typedef struct packed {
		logic [14:0]        released;
		logic [12:0]        receptor;
		logic [14:0]        unbound;
		logic signed [15:0] current;
		logic [14:0]        available;
	} tick_out_t;

	typedef struct packed {
		logic      pin;
		tick_out_t res;
	} known_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               spike = 1'b0;
	logic [14:0]        spike_weight = '0;
	logic signed [15:0] goodwin_y = '0;
	logic signed [15:0] goodwin_weight = '0;
	logic signed [15:0] ecb_level = '0;
	logic signed [15:0] ecb_weight = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [14:0]        released;
	logic [12:0]        receptor_level;
	logic [14:0]        unbound_level;
	logic signed [15:0] current_trace;
	logic [14:0]        available_level;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [14:0]        cfg_data = '0;

	presynaptic_release_cb1_adaptation dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.spike           (spike),
		.spike_weight    (spike_weight),
		.goodwin_y       (goodwin_y),
		.goodwin_weight  (goodwin_weight),
		.ecb_level       (ecb_level),
		.ecb_weight      (ecb_weight),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.released        (released),
		.receptor_level  (receptor_level),
		.unbound_level   (unbound_level),
		.current_trace   (current_trace),
		.available_level (available_level),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// bouton model state and config copy
	longint k_rise = 410, k_fall = 410, k_recover = 410, k_rate = 0, k_max = 4096;
	bit     goodwin_on = 1'b0, ecb_on = 1'b0;
	longint receptor_st = 0, rise_st = 0, cur_st = 0, avail_st = 0;

	tick_out_t tick_results_q [$];
	known_t    typed_expect_q [$];
	int        mismatches = 0;
	int        send_idle = 0;
	int        recv_idle = 0;
	int        hold_left = 0;
	int        idle_cycles = 0;

	function automatic longint q_mul(longint a, longint b);
		return (a * b) >>> 12;
	endfunction

	function automatic longint sat(longint x, longint lo, longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic tick_out_t bouton_tick(input tick_in_t t);
		tick_out_t r;
		longint    rel, ecb, unb, m, a;
		rel = 0;
		ecb = 0;
		if (t.spike)
			rel = sat(q_mul(avail_st, longint'(t.sw)), 0, 32767);
		if (goodwin_on)
			receptor_st = sat(q_mul(longint'(t.gy), longint'(t.gw)), 0, Q_ONE);
		if (ecb_on) begin
			ecb = sat(q_mul(longint'(t.el), longint'(t.ew)), -32768, 32767);
			unb = sat(receptor_st - ecb, 0, 32767);
			rise_st = sat(rise_st + q_mul(ecb - rise_st, k_rise), -32768, 32767);
		end else begin
			unb = receptor_st;
			rise_st = 0;
		end
		cur_st = sat(cur_st + q_mul(rise_st - cur_st, k_fall), -32768, 32767);
		m = (ecb < receptor_st) ? ecb : receptor_st;
		a = avail_st + q_mul(k_max - avail_st, k_recover) - q_mul(k_rate, m);
		avail_st = sat(a, 0, 32767);
		r.released  = 15'(rel);
		r.receptor  = 13'(receptor_st);
		r.unbound   = 15'(unb);
		r.current   = 16'(cur_st);
		r.available = 15'(avail_st);
		return r;
	endfunction

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			$display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	// transfers on both channels and config writes, sampled at the edge
	always @(posedge clk) begin
		tick_out_t got, want;
		known_t    kn;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{released, receptor_level, unbound_level, current_trace,
					available_level};
				if (tick_results_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = tick_results_q.pop_front();
					check_field("released", int'(want.released), int'(got.released));
					check_field("receptor_level", int'(want.receptor), int'(got.receptor));
					check_field("unbound_level", int'(want.unbound), int'(got.unbound));
					check_field("current_trace", int'(want.current), int'(got.current));
					check_field("available_level", int'(want.available),
						int'(got.available));
				end
			end
			if (in_valid && !in_stall) begin
				want = bouton_tick('{spike, spike_weight, goodwin_y, goodwin_weight,
					ecb_level, ecb_weight});
				kn = typed_expect_q.pop_front();
				tick_results_q.push_back(kn.pin ? kn.res : want);
			end
			if (cfg_we) begin
				case (cfg_index)
					cb1a_pkg::CFG_RISE_STEP:    k_rise = longint'(cfg_data[12:0]);
					cb1a_pkg::CFG_FALL_STEP:    k_fall = longint'(cfg_data[12:0]);
					cb1a_pkg::CFG_RECOVER_STEP: k_recover = longint'(cfg_data[12:0]);
					cb1a_pkg::CFG_ADAPT_RATE:   k_rate = longint'(cfg_data[14:0]);
					cb1a_pkg::CFG_MAX_TRANS:    k_max = longint'(cfg_data[14:0]);
					cb1a_pkg::CFG_GOODWIN_CONN: goodwin_on = cfg_data[0];
					cb1a_pkg::CFG_ECB_CONN:     ecb_on = cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stall, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	function automatic tick_in_t make_in(logic sp, logic [14:0] sw, logic signed [15:0] gy,
		logic signed [15:0] gw, logic signed [15:0] el, logic signed [15:0] ew);
		return '{sp, sw, gy, gw, el, ew};
	endfunction

	function automatic logic signed [15:0] rnd_q();
		logic signed [15:0] v;
		case ($urandom_range(5))
			0: v = S_MAX;
			1: v = S_MIN;
			2, 3: v = 16'($urandom_range(12288)) - 16'sd6144;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	function automatic tick_in_t rand_in();
		logic [14:0] sw;
		case ($urandom_range(4))
			0: sw = U_MAX;
			1: sw = '0;
			2: sw = 15'($urandom_range(8192));
			default: sw = 15'($urandom);
		endcase
		return make_in(1'($urandom_range(1)), sw, rnd_q(), rnd_q(), rnd_q(), rnd_q());
	endfunction

	function automatic int rnd_step();
		return ($urandom_range(3) == 0) ? int'($urandom_range(8191)) :
			int'($urandom_range(Q_ONE));
	endfunction

	task automatic offer_tick(input tick_in_t t);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		spike          <= t.spike;
		spike_weight   <= t.sw;
		goodwin_y      <= t.gy;
		goodwin_weight <= t.gw;
		ecb_level      <= t.el;
		ecb_weight     <= t.ew;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 15'(val);
		@(posedge clk);
	endtask

	task automatic program_bouton(input int rise, input int fall, input int recover,
		input int rate, input int maxt, input int gw_conn, input int ecb_conn);
		cfg_write(cb1a_pkg::CFG_RISE_STEP, rise);
		cfg_write(cb1a_pkg::CFG_FALL_STEP, fall);
		cfg_write(cb1a_pkg::CFG_RECOVER_STEP, recover);
		cfg_write(cb1a_pkg::CFG_ADAPT_RATE, rate);
		cfg_write(cb1a_pkg::CFG_MAX_TRANS, maxt);
		cfg_write(cb1a_pkg::CFG_GOODWIN_CONN, gw_conn);
		cfg_write(cb1a_pkg::CFG_ECB_CONN, ecb_conn);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		tick_in_t  dir_stim [DIR_N];
		tick_out_t dir_known [DIR_KNOWN];
		known_t    kn;

		// defaults, nothing connected
		dir_stim[0]  = make_in(1'b1, U_MAX, S_0, S_0, S_0, S_0);
		dir_stim[1]  = make_in(1'b1, 15'd4096, S_0, S_0, S_0, S_0);
		dir_stim[2]  = make_in(1'b0, U_MAX, S_MAX, S_MAX, S_MIN, S_MIN);
		dir_stim[3]  = make_in(1'b1, 15'd0, S_MIN, S_MAX, S_MAX, S_MAX);
		dir_stim[4]  = make_in(1'b1, U_MAX, S_ONE, S_ONE, S_ONE, S_ONE);
		// full-scale steps and rate, both inputs connected
		dir_stim[5]  = make_in(1'b0, 15'd0, S_MAX, S_MAX, S_MAX, S_MAX);
		dir_stim[6]  = make_in(1'b0, 15'd16384, S_MAX, S_MAX, S_MIN, S_MAX);
		dir_stim[7]  = make_in(1'b1, U_MAX, S_MIN, S_MAX, S_0, S_0);
		dir_stim[8]  = make_in(1'b1, U_MAX, S_MIN, S_MIN, S_MAX, S_MIN);
		dir_stim[9]  = make_in(1'b1, 15'd1, S_ONE, S_ONE, S_MIN, S_MIN);
		dir_stim[10] = make_in(1'b0, 15'd4096, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
		dir_stim[11] = make_in(1'b1, 15'd8192, 16'sd2048, S_ONE, 16'sd1024, S_ONE);
		dir_stim[12] = make_in(1'b0, 15'd0, 16'sd4095, 16'sd4097, 16'sd16, -16'sd16);
		dir_stim[13] = make_in(1'b1, U_MAX, S_0, S_0, -16'sd4096, S_ONE);
		dir_stim[14] = make_in(1'b0, 15'd0, S_0, S_0, S_0, S_0);
		dir_stim[15] = make_in(1'b1, 15'd2048, 16'sd6144, 16'sd2730, -16'sd2048, 16'sd8192);
		dir_known[0] = '{15'd0, 13'd0, 15'd0, 16'sd0, 15'd410};
		dir_known[1] = '{15'd410, 13'd0, 15'd0, 16'sd0, 15'd778};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 24;
		recv_idle = 52;
		for (int i = 0; i < DIR_N; i++) begin
			if (i == DIR_SPLIT) begin
				drain();
				program_bouton(8191, 8191, 8191, 32767, 32767, 1, 1);
			end
			kn = '0;
			if (i < DIR_KNOWN)
				kn = '{1'b1, dir_known[i]};
			typed_expect_q.push_back(kn);
			offer_tick(dir_stim[i]);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			send_idle = (p < 2) ? 24 : ((p < 4) ? 52 : 0);
			recv_idle = (p < 2) ? 52 : ((p < 4) ? 24 : 0);
			case (p)
				0: program_bouton(8191, 8191, 8191, 32767, 32767, 1, 1);
				1: program_bouton(0, 0, 0, 0, 0, 1, 1);
				2: program_bouton(Q_ONE, Q_ONE, Q_ONE, int'($urandom_range(8192)),
					int'($urandom_range(32767)), 1, 0);
				3: program_bouton(rnd_step(), rnd_step(), rnd_step(),
					int'($urandom_range(16384)), int'($urandom_range(32767)), 0, 1);
				default: program_bouton(rnd_step(), rnd_step(), rnd_step(),
					int'($urandom_range(32767)), int'($urandom_range(32767)),
					int'($urandom_range(1)), int'($urandom_range(1)));
			endcase
			// in phase 1 the result side holds off while items keep coming
			if (p == 1)
				hold_left = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				typed_expect_q.push_back('0);
				offer_tick(rand_in());
			end
		end
		drain();

		if (mismatches == 0 && tick_results_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
